/* src/staged_current_regulator_top_defines.svh */
// assertion macros for the staged current regulator
// used by staged_current_regulator_top; no other dependencies
`ifndef STAGED_CURRENT_REGULATOR_TOP_DEFINES_SVH
`define STAGED_CURRENT_REGULATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SCR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("staged current regulator check failed");

// next-cycle implication, disabled during reset
`define SCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("staged current regulator check failed");

`endif

/* src/scr_pkg.sv */
// package for the staged current regulator: types, codes and constants
// no dependencies; used by scr_div and staged_current_regulator_top
package scr_pkg;

  localparam int unsigned DVD_W = 22;
  localparam int unsigned DVS_W = 12;
  localparam int unsigned CNT_W = 5;

  localparam logic [3:0] F_O1C1 = 4'b0001;
  localparam logic [3:0] F_O2C2 = 4'b0010;
  localparam logic [3:0] F_O2C1 = 4'b0100;
  localparam logic [3:0] F_O1C2 = 4'b1000;
  localparam logic [3:0] STAGE1 = F_O1C1;
  localparam logic [3:0] STAGE2 = F_O1C1 | F_O1C2;
  localparam logic [3:0] STAGE3 = F_O1C1 | F_O1C2 | F_O2C1;
  localparam logic [3:0] STAGE4 = F_O1C1 | F_O1C2 | F_O2C1 | F_O2C2;

  localparam logic [11:0] STAGE_A_LIM  = 12'd250;
  localparam logic [11:0] STAGE_B_LIM  = 12'd500;
  localparam logic [11:0] STAGE_C_LIM  = 12'd750;
  localparam logic [11:0] DAC_THR_ONE  = 12'd120;
  localparam logic [11:0] DAC_THR_MANY = 12'd100;
  localparam logic [11:0] DAC_STEP     = 12'd50;
  localparam logic [11:0] DAC_TOP      = 12'd4000;
  localparam logic [9:0]  PWM_MAX      = 10'd1023;
  localparam logic [10:0] PWM_KICK     = 11'd10;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_SHARED = 2'd1,
    MODE_DUAL   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_LIMIT    = 3'd1,
    REG_CEILING  = 3'd2,
    REG_TOL      = 3'd3,
    REG_BASE_ONE = 3'd4,
    REG_BASE_TWO = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CLAMP,
    S_EVAL,
    S_FMUL,
    S_DSTART,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* src/scr_div.sv */
// restoring serial divider, one quotient bit per cycle
// depends on scr_pkg for widths and the control/status structs
module scr_div
  import scr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_ctrl_t        ctrl,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [DVD_W-1:0] quotient
);

  logic [DVD_W-1:0] q;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem, q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      q   <= {q[DVD_W-2:0], ge};
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = q;

endmodule

/* src/staged_current_regulator_top.sv */
// staged current regulator: top level with sequencer, shared multiplier and state
// depends on scr_pkg, scr_div and staged_current_regulator_top_defines.svh
// sequence: accept, then S_MUL, S_CLAMP, S_EVAL and S_DONE for step/DAC/hold paths;
//   the ratio jump adds S_FMUL, S_DSTART and S_DIV (the serial divider) before S_DONE
// one item at a time; next item accepted once the result is loaded
//   into the output register, and S_DONE waits while the output is stalled
// reset: synchronous active-high rst clears state, flags, levels and config
`include "staged_current_regulator_top_defines.svh"

module staged_current_regulator_top
  import scr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  // target_req[11:0], current_fraction[20:12], measured_current[32:21],
  // output_select[33], use_formula[34], over_temp[35], zero pad[39:36]
  input  logic [39:0] s_tdata,
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // applied[0], pwm_first[10:1], pwm_second[20:11], channel_enables[24:21],
  // dac_level[36:25], zero pad[39:37]
  output logic [39:0] m_tdata
);

  // configuration registers
  logic [1:0]  mode;
  logic [11:0] current_limit;
  logic [9:0]  pwm_ceiling;
  logic [7:0]  tolerance;
  logic [9:0]  base_pwm_one;
  logic [9:0]  base_pwm_two;

  // regulator state
  logic [9:0]  pwm_levels [2];
  logic [11:0] dac_levels [2];
  logic [3:0]  channel_flags;

  // sequencer
  state_t state;
  state_t state_next;

  // captured item
  logic [11:0] target;
  logic [8:0]  frac;
  logic [11:0] meas;
  logic        sel;
  logic        formula;
  logic        ot;

  // working registers
  logic [21:0] prod;
  logic [11:0] des;
  logic [9:0]  pwm_w;
  logic        applied;

  // shared multiplier operands
  logic [11:0] mul_a;
  logic [9:0]  mul_b;

  // handshake and sequencing controls
  logic      in_acc;
  logic      out_load;
  div_ctrl_t div_ctrl;
  div_stat_t div_stat;
  logic [DVD_W-1:0] div_q;

  // evaluation results
  logic        in_band;
  logic [11:0] err;
  logic [11:0] thresh;
  logic [3:0]  flags_new;
  logic [9:0]  pwm_z;
  logic [9:0]  pwm_new;
  logic [11:0] dac_new;
  logic        go_formula;
  logic        rising;
  logic        room;
  logic [10:0] pwm_up;
  logic [3:0]  stage_f;
  logic [3:0]  c1;
  logic [3:0]  c2;
  logic        valid_stage;
  logic [9:0]  q_sat;
  logic [9:0]  cur_pwm;
  logic [11:0] cur_dac;

  assign in_acc = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_tvalid) state_next = S_MUL;
      S_MUL:    state_next = S_CLAMP;
      S_CLAMP:  state_next = S_EVAL;
      S_EVAL:   state_next = (!in_band && go_formula) ? S_FMUL : S_DONE;
      S_FMUL:   state_next = S_DSTART;
      S_DSTART: state_next = S_DIV;
      S_DIV:    if (div_stat.done) state_next = S_DONE;
      S_DONE:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    s_tready       = 1'b0;
    div_ctrl.start = 1'b0;
    out_load       = 1'b0;
    mul_a          = target;
    mul_b          = {1'b0, frac};
    unique case (state)
      S_IDLE:   s_tready = 1'b1;
      S_FMUL: begin
        // ratio jump numerator: pwm * desired
        mul_a = des;
        mul_b = pwm_w;
      end
      S_DSTART: div_ctrl.start = 1'b1;
      S_DONE:   out_load = !m_tvalid || m_tready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // ---------------------------------------------------------------------------
  // evaluation of one tick from the clamped desired current
  // ---------------------------------------------------------------------------
  assign cur_pwm = pwm_levels[sel];
  assign cur_dac = dac_levels[sel];
  assign err     = (des > meas) ? (des - meas) : (meas - des);
  assign in_band = err < {4'd0, tolerance};
  assign rising  = des > meas;

  // four-stage pattern from the desired current
  always_comb begin
    if (des < STAGE_A_LIM)      stage_f = STAGE1;
    else if (des < STAGE_B_LIM) stage_f = STAGE2;
    else if (des < STAGE_C_LIM) stage_f = STAGE3;
    else                        stage_f = STAGE4;
  end

  assign valid_stage = (channel_flags == STAGE1) || (channel_flags == STAGE2) ||
                       (channel_flags == STAGE3) || (channel_flags == STAGE4);
  assign c1 = sel ? F_O2C1 : F_O1C1;
  assign c2 = sel ? F_O2C2 : F_O1C2;

  // stage selection, zeroing the output pwm on a stage change in shared and dual modes
  always_comb begin
    flags_new = channel_flags;
    pwm_z     = cur_pwm;
    thresh    = '0;
    case (mode)
      MODE_SINGLE: begin
        flags_new = STAGE1;
        thresh    = DAC_THR_ONE;
      end
      MODE_SHARED: begin
        if (valid_stage && channel_flags != stage_f) pwm_z = '0;
        flags_new = stage_f;
        thresh    = DAC_THR_MANY;
      end
      MODE_DUAL: begin
        if (des < STAGE_B_LIM) begin
          if ((channel_flags & c2) != '0) pwm_z = '0;
          flags_new = (channel_flags & ~c2) | c1;
        end else begin
          if ((channel_flags & c2) == '0) pwm_z = '0;
          flags_new = channel_flags | c1 | c2;
        end
        thresh = DAC_THR_MANY;
      end
      default: begin
        // unused mode keeps the flags, no dac region
      end
    endcase
  end

  assign room   = rising ? (pwm_z < pwm_ceiling) : (pwm_z != '0);
  assign pwm_up = {1'b0, pwm_z} + ((meas == '0) ? PWM_KICK : 11'd1);

  // region choice and pwm/dac update
  always_comb begin
    pwm_new    = pwm_z;
    dac_new    = cur_dac;
    go_formula = 1'b0;
    if (des == '0) begin
      pwm_new = '0;
      dac_new = '0;
    end else if (des < thresh) begin
      // low-current dac region
      pwm_new = (mode == MODE_DUAL && sel) ? base_pwm_two : base_pwm_one;
      if (rising) begin
        if (cur_dac >= DAC_STEP) dac_new = cur_dac - DAC_STEP;
      end else begin
        if (cur_dac < DAC_TOP) dac_new = cur_dac + DAC_STEP;
      end
    end else begin
      dac_new = '0;
      if (room) begin
        if (meas == '0 || (!ot && !formula && rising)) begin
          // zero current kick or single step up, both saturating
          pwm_new = pwm_up[10] ? PWM_MAX : pwm_up[9:0];
        end else if (!ot && formula) begin
          go_formula = 1'b1;
        end else if (!ot) begin
          pwm_new = pwm_z - 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // serial divider for the ratio jump
  // ---------------------------------------------------------------------------
  scr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (prod),
    .divisor  (meas),
    .stat     (div_stat),
    .quotient (div_q)
  );

  assign q_sat = (div_q[DVD_W-1:10] != '0) ? PWM_MAX : div_q[9:0];

  // ---------------------------------------------------------------------------
  // config and regulator state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_SINGLE;
      current_limit <= 12'd4095;
      pwm_ceiling   <= 10'd1023;
      tolerance     <= 8'd10;
      base_pwm_one  <= '0;
      base_pwm_two  <= '0;
      pwm_levels[0] <= '0;
      pwm_levels[1] <= '0;
      dac_levels[0] <= '0;
      dac_levels[1] <= '0;
      channel_flags <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:     mode          <= cfg_data[1:0];
          REG_LIMIT:    current_limit <= cfg_data;
          REG_CEILING:  pwm_ceiling   <= cfg_data[9:0];
          REG_TOL:      tolerance     <= cfg_data[7:0];
          REG_BASE_ONE: base_pwm_one  <= cfg_data[9:0];
          REG_BASE_TWO: base_pwm_two  <= cfg_data[9:0];
          default: begin
          end
        endcase
      end
      if (state == S_EVAL && !in_band) begin
        channel_flags   <= flags_new;
        pwm_levels[sel] <= pwm_new;
        dac_levels[sel] <= dac_new;
      end
      if (state == S_DIV && div_stat.done) pwm_levels[sel] <= q_sat;
      if (out_load)           m_tvalid <= 1'b1;
      else if (m_tready)      m_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers, no reset
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      target  <= s_tdata[11:0];
      frac    <= s_tdata[20:12];
      meas    <= s_tdata[32:21];
      sel     <= s_tdata[33];
      formula <= s_tdata[34];
      ot      <= s_tdata[35];
    end
    // shared multiplier, registered
    if (state == S_MUL || state == S_FMUL) prod <= 22'(mul_a) * 22'(mul_b);
    // desired = min(target*fraction/256 truncated to 12 bits, limit)
    if (state == S_CLAMP) des <= (prod[19:8] > current_limit) ? current_limit : prod[19:8];
    if (state == S_EVAL) begin
      pwm_w   <= pwm_z;
      applied <= !in_band;
    end
    if (out_load) begin
      m_tdata <= {3'd0, dac_levels[sel], channel_flags,
                  (mode == MODE_SHARED) ? pwm_levels[0] : pwm_levels[1],
                  pwm_levels[0], applied};
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `SCR_ASSERT_NEXT(a_accept_starts, clk, rst, in_acc, state == S_MUL)
  `SCR_ASSERT_NOW(a_div_done_in_div, clk, rst, div_stat.done, state == S_DIV)
  `SCR_ASSERT_NOW(a_dac_range, clk, rst, 1'b1,
                  dac_levels[0] <= 12'd4050 && dac_levels[1] <= 12'd4050)

endmodule
